[src/rational_arithmetic_unit_top_macros.svh]
// Assertion macros shared by the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_MACROS_SVH

// Same-cycle implication, sampled on aclk and held off during reset.
`define RAU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rational unit: same-cycle check failed");

// Next-cycle implication, sampled on aclk and held off during reset.
`define RAU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rational unit: next-cycle check failed");

`endif

[src/rau_pkg.sv]
// Package with widths, field layout and mode codes of the rational arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int FIELD_W       = 16;
    localparam int MODE_W        = 3;
    localparam int NUM_W         = 33;
    localparam int DEN_W         = 31;

    localparam int MW = 2 * OPERAND_WIDTH;
    localparam int PW = (2 * OPERAND_WIDTH + 2 > 64) ? 64 : 2 * OPERAND_WIDTH + 2;
    localparam int SW = PW + 1;
    localparam int CW = $clog2(PW);

    localparam int ONW = (PW > NUM_W) ? PW : NUM_W;
    localparam int ODW = (PW > DEN_W) ? PW : DEN_W;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD     = 3'd0,
        MODE_SUB     = 3'd1,
        MODE_MUL     = 3'd2,
        MODE_DIV     = 3'd3,
        MODE_EQUAL   = 3'd4,
        MODE_GREATER = 3'd5,
        MODE_LESS    = 3'd6
    } rau_mode_t;

endpackage

`default_nettype wire

[src/rational_arithmetic_unit_top.sv]
// Top level of the rational arithmetic unit: sequencer around one multiplier and one adder.
//
// Each item carries two fractions and a mode (add, subtract, multiply, divide, equal,
// greater, less) and gives one result item. Arithmetic results are reduced by their
// greatest common divisor, carry the sign in the numerator and show zero as 0/1;
// compare modes answer in compare_true from exact cross products. A zero denominator,
// a division by zero or the unused mode code sets status with all other fields zero.
// The unit holds one item at a time: s_tready is high only while the sequencer is idle,
// and the result waits in the output register so the next item can enter meanwhile.
// An error item goes from idle straight to the output state, and a compare item leaves
// after the combine state. An arithmetic item also runs the binary GCD loop and two
// restoring divisions by the GCD, which take one bit per cycle each on the single shared
// adder, and the GCD loop does one shift, one swap or one subtract-and-shift per cycle
// on that same adder.
`timescale 1ns / 1ps
`default_nettype none

`include "rational_arithmetic_unit_top_macros.svh"

module rational_arithmetic_unit_top
    import rau_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // mode[2:0], left_num[18:3], left_den[34:19], right_num[50:35], right_den[66:51]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // res_num[32:0], res_den[63:33]
    output logic [M_TDATA_W-1:0]      m_tdata,
    // compare_true[0], status[1]
    output logic [M_TUSER_W-1:0]      m_tuser
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL0, ST_MUL1, ST_MUL2, ST_COMB, ST_DNEG, ST_NNEG, ST_NABS,
        ST_GTWO, ST_GCD, ST_GFIX, ST_DIVN, ST_DIVD, ST_FIN, ST_OUT
    } state_t;

    state_t state_reg;

    rau_mode_t mode_reg;
    logic signed [OPERAND_WIDTH-1:0] ln_reg, ld_reg, rn_reg, rd_reg;
    logic signed [MW-1:0] p0_reg, p1_reg, pd_reg;
    logic [PW-1:0] n_reg, d_reg, u_reg, v_reg, q_reg, rem_reg;
    logic [CW-1:0] k_reg, cnt_reg;
    logic dneg_reg, neg_reg;
    logic [NUM_W-1:0] res_num_reg;
    logic [DEN_W-1:0] res_den_reg;
    logic res_cmp_reg, res_status_reg;
    logic m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TUSER_W-1:0] m_user_reg;

    logic [31:0] in_ln_w, in_ld_w, in_rn_w, in_rd_w;
    logic [OPERAND_WIDTH-1:0] in_ln, in_ld, in_rn, in_rd;
    logic [MODE_W-1:0] in_mode;
    logic in_error;

    assign in_mode = s_tdata[2:0];
    assign in_ln_w = 32'(s_tdata[18:3]);
    assign in_ld_w = 32'(s_tdata[34:19]);
    assign in_rn_w = 32'(s_tdata[50:35]);
    assign in_rd_w = 32'(s_tdata[66:51]);
    assign in_ln   = in_ln_w[OPERAND_WIDTH-1:0];
    assign in_ld   = in_ld_w[OPERAND_WIDTH-1:0];
    assign in_rn   = in_rn_w[OPERAND_WIDTH-1:0];
    assign in_rd   = in_rd_w[OPERAND_WIDTH-1:0];
    assign in_error = (in_ld == '0) || (in_rd == '0) || (in_mode > MODE_LESS) ||
                      ((in_mode == MODE_DIV) && (in_rn == '0));

    logic signed [OPERAND_WIDTH-1:0] mul_a, mul_b;
    logic signed [MW-1:0] mul_y;
    assign mul_y = mul_a * mul_b;

    logic [SW-1:0] add_a, add_b, add_y;
    logic add_sub;
    assign add_y = add_a + (add_sub ? ~add_b : add_b) + SW'(add_sub);

    always_comb begin
        mul_a = ln_reg;
        mul_b = rd_reg;
        unique case (state_reg)
            ST_MUL0: begin
                mul_a = ln_reg;
                mul_b = (mode_reg == MODE_MUL) ? rn_reg : rd_reg;
            end
            ST_MUL1: begin
                mul_a = rn_reg;
                mul_b = ld_reg;
            end
            ST_MUL2: begin
                mul_a = ld_reg;
                mul_b = (mode_reg == MODE_DIV) ? rn_reg : rd_reg;
            end
            default: begin
                mul_a = ln_reg;
                mul_b = rd_reg;
            end
        endcase
    end

    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b1;
        unique case (state_reg)
            ST_COMB: begin
                add_a   = SW'(p0_reg);
                add_b   = SW'(p1_reg);
                add_sub = (mode_reg != MODE_ADD);
            end
            ST_DNEG: add_b = SW'(d_reg);
            ST_NNEG, ST_NABS, ST_FIN: add_b = SW'(n_reg);
            ST_GCD: begin
                add_a = SW'(u_reg);
                add_b = SW'(v_reg);
            end
            ST_DIVN, ST_DIVD: begin
                add_a = {rem_reg, q_reg[PW-1]};
                add_b = SW'(v_reg);
            end
            default: begin
                add_a   = '0;
                add_b   = '0;
                add_sub = 1'b1;
            end
        endcase
    end

    logic cmp_lt, cmp_eq, cmp_gt, cmp_flip, cmp_r;
    assign cmp_lt   = add_y[SW-1];
    assign cmp_eq   = (add_y == '0);
    assign cmp_gt   = !cmp_lt && !cmp_eq;
    assign cmp_flip = ld_reg[OPERAND_WIDTH-1] ^ rd_reg[OPERAND_WIDTH-1];

    always_comb begin
        case (mode_reg)
            MODE_EQUAL:   cmp_r = cmp_eq;
            MODE_GREATER: cmp_r = cmp_flip ? cmp_lt : cmp_gt;
            default:      cmp_r = cmp_flip ? cmp_gt : cmp_lt;
        endcase
    end

    logic div_ok;
    logic [PW-1:0] q_next, rem_next;
    assign div_ok   = !add_y[SW-1];
    assign q_next   = {q_reg[PW-2:0], div_ok};
    assign rem_next = div_ok ? add_y[PW-1:0] : add_a[PW-1:0];

    logic signed [PW-1:0] fin_num;
    assign fin_num = neg_reg ? add_y[PW-1:0] : n_reg;

    logic m_free;
    assign m_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        mode_reg <= rau_mode_t'(in_mode);
                        ln_reg   <= in_ln;
                        ld_reg   <= in_ld;
                        rn_reg   <= in_rn;
                        rd_reg   <= in_rd;
                        if (in_error) begin
                            res_num_reg    <= '0;
                            res_den_reg    <= '0;
                            res_cmp_reg    <= 1'b0;
                            res_status_reg <= 1'b1;
                            state_reg      <= ST_OUT;
                        end else begin
                            state_reg <= ST_MUL0;
                        end
                    end
                end
                ST_MUL0: begin
                    p0_reg    <= mul_y;
                    state_reg <= ST_MUL1;
                end
                ST_MUL1: begin
                    p1_reg    <= mul_y;
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    pd_reg    <= mul_y;
                    state_reg <= ST_COMB;
                end
                ST_COMB: begin
                    if (mode_reg >= MODE_EQUAL) begin
                        res_num_reg    <= '0;
                        res_den_reg    <= '0;
                        res_cmp_reg    <= cmp_r;
                        res_status_reg <= 1'b0;
                        state_reg      <= ST_OUT;
                    end else begin
                        if (mode_reg == MODE_ADD || mode_reg == MODE_SUB) begin
                            n_reg <= add_y[PW-1:0];
                        end else begin
                            n_reg <= PW'(p0_reg);
                        end
                        d_reg     <= PW'(pd_reg);
                        state_reg <= ST_DNEG;
                    end
                end
                ST_DNEG: begin
                    dneg_reg <= d_reg[PW-1];
                    if (d_reg[PW-1]) begin
                        d_reg <= add_y[PW-1:0];
                    end
                    state_reg <= ST_NNEG;
                end
                ST_NNEG: begin
                    if (dneg_reg) begin
                        n_reg <= add_y[PW-1:0];
                    end
                    state_reg <= ST_NABS;
                end
                ST_NABS: begin
                    neg_reg <= n_reg[PW-1];
                    if (d_reg == '0) begin
                        res_num_reg    <= '0;
                        res_den_reg    <= '0;
                        res_cmp_reg    <= 1'b0;
                        res_status_reg <= 1'b1;
                        state_reg      <= ST_OUT;
                    end else begin
                        if (n_reg[PW-1]) begin
                            n_reg <= add_y[PW-1:0];
                            u_reg <= add_y[PW-1:0];
                        end else begin
                            u_reg <= n_reg;
                        end
                        v_reg     <= d_reg;
                        k_reg     <= '0;
                        state_reg <= ST_GTWO;
                    end
                end
                ST_GTWO: begin
                    if (u_reg == '0) begin
                        rem_reg   <= '0;
                        q_reg     <= n_reg;
                        cnt_reg   <= CW'(PW - 1);
                        state_reg <= ST_DIVN;
                    end else if (!u_reg[0] && !v_reg[0]) begin
                        u_reg <= u_reg >> 1;
                        v_reg <= v_reg >> 1;
                        k_reg <= k_reg + CW'(1);
                    end else begin
                        state_reg <= ST_GCD;
                    end
                end
                ST_GCD: begin
                    if (u_reg == '0) begin
                        state_reg <= ST_GFIX;
                    end else if (!u_reg[0]) begin
                        u_reg <= u_reg >> 1;
                    end else if (!v_reg[0]) begin
                        v_reg <= v_reg >> 1;
                    end else if (add_y[SW-1]) begin
                        u_reg <= v_reg;
                        v_reg <= u_reg;
                    end else begin
                        u_reg <= add_y[PW:1];
                    end
                end
                ST_GFIX: begin
                    if (k_reg != '0) begin
                        v_reg <= v_reg << 1;
                        k_reg <= k_reg - CW'(1);
                    end else begin
                        rem_reg   <= '0;
                        q_reg     <= n_reg;
                        cnt_reg   <= CW'(PW - 1);
                        state_reg <= ST_DIVN;
                    end
                end
                ST_DIVN: begin
                    if (cnt_reg == '0) begin
                        n_reg     <= q_next;
                        rem_reg   <= '0;
                        q_reg     <= d_reg;
                        cnt_reg   <= CW'(PW - 1);
                        state_reg <= ST_DIVD;
                    end else begin
                        rem_reg <= rem_next;
                        q_reg   <= q_next;
                        cnt_reg <= cnt_reg - CW'(1);
                    end
                end
                ST_DIVD: begin
                    if (cnt_reg == '0) begin
                        d_reg     <= q_next;
                        state_reg <= ST_FIN;
                    end else begin
                        rem_reg <= rem_next;
                        q_reg   <= q_next;
                        cnt_reg <= cnt_reg - CW'(1);
                    end
                end
                ST_FIN: begin
                    res_num_reg    <= NUM_W'(ONW'(fin_num));
                    res_den_reg    <= DEN_W'(ODW'(d_reg));
                    res_cmp_reg    <= 1'b0;
                    res_status_reg <= 1'b0;
                    state_reg      <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_free) begin
                        m_data_reg  <= {res_den_reg, res_num_reg};
                        m_user_reg  <= {res_status_reg, res_cmp_reg};
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `RAU_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `RAU_ASSERT_NOW(a_error_fields_zero, m_tvalid && m_tuser[1],
        (m_tdata == '0) && !m_tuser[0])
    `RAU_ASSERT_NOW(a_compare_fields_zero, m_tvalid && m_tuser[0],
        (m_tdata == '0) && !m_tuser[1])
    `RAU_ASSERT_NOW(a_gcd_divisor_nonzero,
        state_reg == ST_GCD || state_reg == ST_GFIX || state_reg == ST_DIVN, v_reg != '0)

endmodule

`default_nettype wire

[dv/rational_arithmetic_unit_top_test.sv]
// Self-checking testbench for the rational arithmetic unit: directed table, then random items.
`timescale 1ns / 1ps

module rational_arithmetic_unit_top_test;
    import rau_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
    localparam int CMP_BIT = 0;
    localparam int STATUS_BIT = 1;
    localparam int RANDOM_ITEMS = 850;
    localparam int PRESSURE_AFTER = 300;
    localparam int PRESSURE_HOLD = 1200;
    localparam int DRAIN_CYCLES = 250;
    localparam int IDLE_LIMIT = 6000;
    localparam int DIRECTED_ROWS = 24;

    typedef struct packed {
        logic signed [NUM_W-1:0] num;
        logic [DEN_W-1:0]        den;
        logic                    cmp;
        logic                    st;
    } fraction_result_t;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [FIELD_W-1:0] ln;
        logic signed [FIELD_W-1:0] ld;
        logic signed [FIELD_W-1:0] rn;
        logic signed [FIELD_W-1:0] rd;
        logic                     typed;
        fraction_result_t         res;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    fraction_result_t pending_fractions[$];
    int fail_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int error_results = 0;
    int true_compares = 0;
    int burst_left = 0;
    bit pressure_done = 0;

    rational_arithmetic_unit_top dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{MODE_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3, 1'b1, '{33'sd5, 31'd6, 1'b0, 1'b0}},
        '{MODE_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd3, 1'b1, '{33'sd1, 31'd6, 1'b0, 1'b0}},
        '{MODE_MUL, 16'sd2, 16'sd3, 16'sd3, 16'sd4, 1'b1, '{33'sd1, 31'd2, 1'b0, 1'b0}},
        '{MODE_DIV, 16'sd1, 16'sd2, 16'sd1, 16'sd4, 1'b1, '{33'sd2, 31'd1, 1'b0, 1'b0}},
        '{MODE_EQUAL, 16'sd1, 16'sd2, 16'sd2, 16'sd4, 1'b1, '{33'sd0, 31'd0, 1'b1, 1'b0}},
        '{MODE_GREATER, 16'sd1, 16'sd2, 16'sd1, 16'sd3, 1'b1, '{33'sd0, 31'd0, 1'b1, 1'b0}},
        '{MODE_LESS, 16'sd1, 16'sd2, 16'sd1, 16'sd3, 1'b1, '{33'sd0, 31'd0, 1'b0, 1'b0}},
        '{MODE_ADD, 16'sd3, 16'sd0, 16'sd1, 16'sd2, 1'b1, '{33'sd0, 31'd0, 1'b0, 1'b1}},
        '{MODE_MUL, 16'sd1, 16'sd2, 16'sd5, 16'sd0, 1'b1, '{33'sd0, 31'd0, 1'b0, 1'b1}},
        '{MODE_DIV, 16'sd1, 16'sd2, 16'sd0, 16'sd3, 1'b1, '{33'sd0, 31'd0, 1'b0, 1'b1}},
        '{MODE_UNUSED, 16'sd1, 16'sd2, 16'sd1, 16'sd3, 1'b1, '{33'sd0, 31'd0, 1'b0, 1'b1}},
        '{MODE_EQUAL, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{33'sd0, 31'd0, 1'b0, 1'b1}},
        '{MODE_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1,
          '{33'sd2, 31'd1, 1'b0, 1'b0}},
        '{MODE_MUL, 16'sd32767, 16'sd1, 16'sd32767, 16'sd1, 1'b0, '0},
        '{MODE_SUB, 16'sh8000, 16'sd1, 16'sd32767, 16'sd1, 1'b0, '0},
        '{MODE_ADD, 16'sd0, 16'sd5, 16'sd0, -16'sd7, 1'b1, '{33'sd0, 31'd1, 1'b0, 1'b0}},
        '{MODE_DIV, 16'sd1, 16'sh8000, 16'sh8000, 16'sd1, 1'b1,
          '{33'sd1, 31'd1073741824, 1'b0, 1'b0}},
        '{MODE_GREATER, 16'sd1, -16'sd2, -16'sd1, 16'sd3, 1'b0, '0},
        '{MODE_LESS, 16'sh8000, 16'sd1, 16'sd32767, 16'sd1, 1'b1,
          '{33'sd0, 31'd0, 1'b1, 1'b0}},
        '{MODE_EQUAL, -16'sd1, -16'sd1, 16'sd1, 16'sd1, 1'b1, '{33'sd0, 31'd0, 1'b1, 1'b0}},
        '{MODE_MUL, 16'sh8000, 16'sd32767, 16'sd32767, 16'sh8000, 1'b0, '0},
        '{MODE_DIV, 16'sd32767, 16'sh8000, 16'sh8000, 16'sd32767, 1'b0, '0},
        '{MODE_ADD, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b1, '{33'sd2, 31'd1, 1'b0, 1'b0}},
        '{MODE_SUB, 16'sd32767, 16'sh8000, 16'sd32767, 16'sh8000, 1'b1,
          '{33'sd0, 31'd1, 1'b0, 1'b0}}
    };

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic fraction_result_t compute_fraction_result(
        input logic [MODE_W-1:0] mode,
        input logic signed [FIELD_W-1:0] ln_f,
        input logic signed [FIELD_W-1:0] ld_f,
        input logic signed [FIELD_W-1:0] rn_f,
        input logic signed [FIELD_W-1:0] rd_f
    );
        longint ln, ld, rn, rd, lhs, rhs, n, d, mag, x, y, t;
        bit neg;
        fraction_result_t r;
        r = '0;
        ln = longint'(ln_f);
        ld = longint'(ld_f);
        rn = longint'(rn_f);
        rd = longint'(rd_f);
        if (ld == 0 || rd == 0 || mode == MODE_UNUSED || (mode == MODE_DIV && rn == 0)) begin
            r.st = 1'b1;
            return r;
        end
        if (mode >= MODE_EQUAL) begin
            if (ld < 0) begin
                ln = -ln;
                ld = -ld;
            end
            if (rd < 0) begin
                rn = -rn;
                rd = -rd;
            end
            lhs = ln * rd;
            rhs = rn * ld;
            case (mode)
                MODE_EQUAL:   r.cmp = (lhs == rhs);
                MODE_GREATER: r.cmp = (lhs > rhs);
                default:      r.cmp = (lhs < rhs);
            endcase
            return r;
        end
        case (mode)
            MODE_ADD: begin
                n = ln * rd + rn * ld;
                d = ld * rd;
            end
            MODE_SUB: begin
                n = ln * rd - rn * ld;
                d = ld * rd;
            end
            MODE_MUL: begin
                n = ln * rn;
                d = ld * rd;
            end
            default: begin
                n = ln * rd;
                d = ld * rn;
            end
        endcase
        if (d < 0) begin
            n = -n;
            d = -d;
        end
        neg = (n < 0);
        mag = neg ? -n : n;
        x = mag;
        y = d;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        mag = mag / x;
        d = d / x;
        r.num = NUM_W'(neg ? -mag : mag);
        r.den = DEN_W'(d);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic offer_fraction_item(
        input logic [MODE_W-1:0] mode,
        input logic signed [FIELD_W-1:0] ln,
        input logic signed [FIELD_W-1:0] ld,
        input logic signed [FIELD_W-1:0] rn,
        input logic signed [FIELD_W-1:0] rd,
        input logic typed,
        input fraction_result_t typed_res
    );
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_TDATA_W - MODE_W - 4 * FIELD_W){1'b0}}, rd, rn, ld, ln, mode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_fractions.push_back(typed ? typed_res
                                          : compute_fraction_result(mode, ln, ld, rn, rd));
        items_sent++;
    endtask

    function automatic logic signed [FIELD_W-1:0] random_operand();
        logic signed [FIELD_W-1:0] extremes [5] = '{16'sh8000, 16'sd32767, -16'sd1, 16'sd1, 16'sd0};
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return extremes[$urandom_range(0, 4)];
        if (pick <= 3) return FIELD_W'($signed($urandom_range(0, 20)) - 10);
        return FIELD_W'($urandom());
    endfunction

    always @(posedge aclk) begin
        fraction_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.num = m_tdata[NUM_W-1:0];
            got.den = m_tdata[NUM_W +: DEN_W];
            got.cmp = m_tuser[CMP_BIT];
            got.st = m_tuser[STATUS_BIT];
            results_seen++;
            if (got.st) error_results++;
            if (got.cmp) true_compares++;
            if (pending_fractions.size() == 0) begin
                report_mismatch("result with no item pending", longint'(got.num), longint'(0));
            end else begin
                want = pending_fractions.pop_front();
                if (got.num !== want.num) begin
                    report_mismatch("res_num", longint'(got.num), longint'(want.num));
                end
                if (got.den !== want.den) begin
                    report_mismatch("res_den", longint'(got.den), longint'(want.den));
                end
                if (got.cmp !== want.cmp) begin
                    report_mismatch("compare_true", longint'(got.cmp), longint'(want.cmp));
                end
                if (got.st !== want.st) begin
                    report_mismatch("status", longint'(got.st), longint'(want.st));
                end
            end
        end
    end

    always @(posedge aclk) begin
        int idle_cycles;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles.", IDLE_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        int pattern, len;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!pressure_done && items_sent >= PRESSURE_AFTER) begin
                m_tready <= 1'b0;
                repeat (PRESSURE_HOLD) @(posedge aclk);
                pressure_done = 1;
            end else begin
                pattern = $urandom_range(0, 3);
                len = $urandom_range(5, 60);
                repeat (len) begin
                    case (pattern)
                        0: m_tready <= 1'b1;
                        1: m_tready <= 1'($urandom_range(0, 1));
                        2: m_tready <= 1'b0;
                        default: m_tready <= ~m_tready;
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    initial begin
        logic [MODE_W-1:0] mode;
        logic signed [FIELD_W-1:0] ln, ld, rn, rd;
        logic signed [FIELD_W-1:0] k;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_rows[i]) begin
            offer_fraction_item(directed_rows[i].mode, directed_rows[i].ln, directed_rows[i].ld,
                                directed_rows[i].rn, directed_rows[i].rd,
                                directed_rows[i].typed, directed_rows[i].res);
        end
        repeat (RANDOM_ITEMS) begin
            mode = ($urandom_range(0, 24) == 0) ? MODE_UNUSED
                                                : MODE_W'($urandom_range(MODE_ADD, MODE_LESS));
            ln = random_operand();
            ld = random_operand();
            rn = random_operand();
            rd = random_operand();
            if (mode == MODE_EQUAL && $urandom_range(0, 1)) begin
                k = FIELD_W'($signed($urandom_range(1, 5)));
                if ($urandom_range(0, 1)) k = -k;
                rn = ln * k;
                rd = ld * k;
            end
            offer_fraction_item(mode, ln, ld, rn, rd, 1'b0, '0);
        end
        s_tvalid <= 1'b0;
        while (pending_fractions.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d items (%0d from the directed table), checked %0d results.",
                 items_sent, DIRECTED_ROWS, results_seen);
        $display("Results with status set: %0d; compares that held: %0d; mismatches: %0d.",
                 error_results, true_compares, fail_count);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
